// ----- rtl/core/lkec_pkg.sv -----
// shared types and constants of the lru keyed entry cache
package lkec_pkg;

  // default number of entries
  localparam int DEPTH_DEF = 16;

  // capacity register
  localparam int             CAP_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // result kinds
  localparam logic [2:0] KIND_HIT   = 3'd0;
  localparam logic [2:0] KIND_MISS  = 3'd1;
  localparam logic [2:0] KIND_INS   = 3'd2;
  localparam logic [2:0] KIND_REPL  = 3'd3;
  localparam logic [2:0] KIND_EVICT = 3'd4;

  // operations
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // one input item
  typedef struct packed {
    logic               operation;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_z;
    logic        [15:0] new_handle;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic        [2:0]  kind;
    logic        [15:0] out_handle;
    logic signed [15:0] out_x;
    logic signed [15:0] out_z;
    logic               last;
  } out_item_t;

  // key and handle of one stored entry
  typedef struct packed {
    logic signed [15:0] key_x;
    logic signed [15:0] key_z;
    logic        [15:0] handle;
  } entry_data_t;

endpackage

// ----- rtl/core/lkec_entry_ram.sv -----
// entry store: key, handle and age per entry, one write and one registered read port
module lkec_entry_ram import lkec_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_idx,
  input  entry_data_t                            wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_age,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_idx,
  output entry_data_t                            rd_data,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_age
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  entry_data_t       data_mem [DEPTH];
  logic [IW-1:0]     age_mem  [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      data_mem[wr_idx] <= wr_data;
      age_mem[wr_idx]  <= wr_age;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= data_mem[rd_idx];
    rd_age  <= age_mem[rd_idx];
  end

endmodule

// ----- rtl/core/lru_keyed_entry_cache.sv -----
// lru keyed entry cache: fully associative handle store with a scanned entry memory
// every pass reads all DEPTH entries through the single memory read port
// lookup miss: the result follows the search pass; hit or replace: search pass, update pass, result
// insert new: the insert result follows the search pass, then an evict pass and result per eviction,
// then an update pass; the next item is taken once the last pass has ended
// synchronous active-low reset clears valid bits and count, capacity returns to 16
module lru_keyed_entry_cache import lkec_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (CW > CAP_W) ? CW + 1 : CAP_W + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [MW-1:0] DEPTH_M  = MW'(DEPTH);

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_UPDATE = 3'd2;
  localparam logic [2:0] ST_EVICT  = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [DEPTH-1:0] valid_r, valid_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             issue_r, issue_nxt;
  logic             rd_vld_r, rd_vld_nxt;

  in_item_t         item_r, item_nxt;
  logic             hit_r, hit_nxt;
  logic [IW-1:0]    hit_idx_r, hit_idx_nxt;
  logic [IW-1:0]    hit_age_r, hit_age_nxt;
  logic [15:0]      hit_handle_r, hit_handle_nxt;
  logic             free_vld_r, free_vld_nxt;
  logic [IW-1:0]    free_idx_r, free_idx_nxt;
  logic [CW-1:0]    evict_left_r, evict_left_nxt;
  logic [IW-1:0]    vic_idx_r, vic_idx_nxt;
  entry_data_t      vic_data_r, vic_data_nxt;
  logic [IW-1:0]    scan_cnt_r, scan_cnt_nxt;
  logic [IW-1:0]    rd_idx_r, rd_idx_nxt;
  out_item_t        res_r, res_nxt;
  out_item_t        out_item_r, out_item_nxt;

  // memory ports
  logic             wr_en;
  logic [IW-1:0]    wr_idx;
  entry_data_t      wr_data;
  logic [IW-1:0]    wr_age;
  entry_data_t      rd_data;
  logic [IW-1:0]    rd_age;

  // decode of the entry under scan
  logic             cur_valid;
  logic             key_match;
  logic             pass_done;
  logic             in_pass;
  logic             start_pass;
  logic             out_load;
  logic [IW-1:0]    oldest_age;
  logic [IW-1:0]    target_idx;
  logic [MW-1:0]    cap_eff;
  logic [MW-1:0]    need_m;
  logic [MW-1:0]    evict_m;

  lkec_entry_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_idx (wr_idx),
    .wr_data(wr_data),
    .wr_age (wr_age),
    .rd_idx (scan_cnt_r),
    .rd_data(rd_data),
    .rd_age (rd_age)
  );

  assign cur_valid  = valid_r[rd_idx_r];
  assign key_match  = cur_valid && (rd_data.key_x == item_r.pos_x) &&
                      (rd_data.key_z == item_r.pos_z);
  assign pass_done  = rd_vld_r && (rd_idx_r == LAST_IDX);
  assign in_pass    = (state_r == ST_SEARCH) || (state_r == ST_UPDATE) ||
                      (state_r == ST_EVICT);
  assign out_load   = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign oldest_age = IW'(count_r - 1'b1);
  assign target_idx = hit_r ? hit_idx_r : free_idx_r;

  // effective capacity and number of entries to evict on a new insert
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = MW'(1);
    end else if (MW'(cap_r) > DEPTH_M) begin
      cap_eff = DEPTH_M;
    end else begin
      cap_eff = MW'(cap_r);
    end
    need_m  = MW'(count_r) + MW'(1);
    evict_m = (need_m > cap_eff) ? (need_m - cap_eff) : '0;
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cap_nxt        = cfg_wr_en ? cfg_wr_data : cap_r;
    count_nxt      = count_r;
    valid_nxt      = valid_r;
    item_nxt       = item_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_age_nxt    = hit_age_r;
    hit_handle_nxt = hit_handle_r;
    free_vld_nxt   = free_vld_r;
    free_idx_nxt   = free_idx_r;
    evict_left_nxt = evict_left_r;
    vic_idx_nxt    = vic_idx_r;
    vic_data_nxt   = vic_data_r;
    res_nxt        = res_r;
    start_pass     = 1'b0;
    wr_en          = 1'b0;
    wr_idx         = rd_idx_r;
    wr_data        = rd_data;
    wr_age         = rd_age;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt     = in_item;
          hit_nxt      = 1'b0;
          free_vld_nxt = 1'b0;
          state_nxt    = ST_SEARCH;
          start_pass   = 1'b1;
        end
      end

      ST_SEARCH: begin
        // first matching key and first free slot
        if (rd_vld_r) begin
          if (key_match && !hit_r) begin
            hit_nxt        = 1'b1;
            hit_idx_nxt    = rd_idx_r;
            hit_age_nxt    = rd_age;
            hit_handle_nxt = rd_data.handle;
          end
          if (!cur_valid && !free_vld_r) begin
            free_vld_nxt = 1'b1;
            free_idx_nxt = rd_idx_r;
          end
        end
        if (pass_done) begin
          res_nxt.out_x = item_r.pos_x;
          res_nxt.out_z = item_r.pos_z;
          if (hit_nxt) begin
            res_nxt.kind       = (item_r.operation == OP_INSERT) ? KIND_REPL : KIND_HIT;
            res_nxt.out_handle = hit_handle_nxt;
            res_nxt.last       = 1'b1;
            state_nxt          = ST_UPDATE;
            start_pass         = 1'b1;
          end else if (item_r.operation == OP_LOOKUP) begin
            res_nxt.kind       = KIND_MISS;
            res_nxt.out_handle = '0;
            res_nxt.last       = 1'b1;
            state_nxt          = ST_EMIT;
          end else begin
            evict_left_nxt     = CW'(evict_m);
            res_nxt.kind       = KIND_INS;
            res_nxt.out_handle = item_r.new_handle;
            res_nxt.last       = (evict_m == '0);
            state_nxt          = ST_EMIT;
          end
        end
      end

      ST_UPDATE: begin
        // age update, write of the promoted or inserted entry
        if (rd_vld_r) begin
          if ((rd_idx_r == target_idx) && (hit_r || free_vld_r)) begin
            wr_en = 1'b1;
            wr_age = '0;
            if (hit_r) begin
              if (item_r.operation == OP_INSERT) begin
                wr_data.handle = item_r.new_handle;
              end
            end else begin
              wr_data.key_x     = item_r.pos_x;
              wr_data.key_z     = item_r.pos_z;
              wr_data.handle    = item_r.new_handle;
              valid_nxt[rd_idx_r] = 1'b1;
              count_nxt         = count_r + 1'b1;
            end
          end else if (cur_valid && (!hit_r || (rd_age < hit_age_r))) begin
            wr_en  = 1'b1;
            wr_age = IW'(rd_age + 1'b1);
          end
        end
        if (pass_done) begin
          state_nxt = hit_r ? ST_EMIT : ST_IDLE;
        end
      end

      ST_EVICT: begin
        // least recent valid entry
        if (rd_vld_r && cur_valid && (rd_age == oldest_age)) begin
          vic_idx_nxt  = rd_idx_r;
          vic_data_nxt = rd_data;
        end
        if (pass_done) begin
          valid_nxt[vic_idx_nxt] = 1'b0;
          count_nxt              = count_r - 1'b1;
          evict_left_nxt         = evict_left_r - 1'b1;
          if (!free_vld_r || (vic_idx_nxt < free_idx_r)) begin
            free_vld_nxt = 1'b1;
            free_idx_nxt = vic_idx_nxt;
          end
          res_nxt.kind       = KIND_EVICT;
          res_nxt.out_handle = vic_data_nxt.handle;
          res_nxt.out_x      = vic_data_nxt.key_x;
          res_nxt.out_z      = vic_data_nxt.key_z;
          res_nxt.last       = (evict_left_r == CW'(1));
          state_nxt          = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_load) begin
          start_pass = 1'b0;
          if ((item_r.operation == OP_INSERT) && !hit_r) begin
            state_nxt  = (evict_left_r != '0) ? ST_EVICT : ST_UPDATE;
            start_pass = 1'b1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // scan address and read pipeline
  always_comb begin
    scan_cnt_nxt = scan_cnt_r;
    issue_nxt    = 1'b0;
    rd_vld_nxt   = 1'b0;
    rd_idx_nxt   = rd_idx_r;
    if (start_pass) begin
      scan_cnt_nxt = '0;
      issue_nxt    = 1'b1;
    end else if (in_pass && issue_r) begin
      rd_vld_nxt   = 1'b1;
      rd_idx_nxt   = scan_cnt_r;
      issue_nxt    = (scan_cnt_r != LAST_IDX);
      scan_cnt_nxt = (scan_cnt_r == LAST_IDX) ? scan_cnt_r : scan_cnt_r + 1'b1;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = res_r;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      issue_r     <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      count_r     <= count_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      issue_r     <= issue_nxt;
      rd_vld_r    <= rd_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_age_r    <= hit_age_nxt;
    hit_handle_r <= hit_handle_nxt;
    free_vld_r   <= free_vld_nxt;
    free_idx_r   <= free_idx_nxt;
    evict_left_r <= evict_left_nxt;
    vic_idx_r    <= vic_idx_nxt;
    vic_data_r   <= vic_data_nxt;
    scan_cnt_r   <= scan_cnt_nxt;
    rd_idx_r     <= rd_idx_nxt;
    res_r        <= res_nxt;
    out_item_r   <= out_item_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
